// ===== rtl/pfc_pkg.sv =====
// Shared constants and result type for the probe frame checker.
package pfc_pkg;

  localparam logic [15:0] FRAME_BYTES   = 16'd1024;
  localparam logic [15:0] HDR_LEN       = 16'd32;
  localparam logic [7:0]  TYPE_PROBE    = 8'd1;
  localparam logic [7:0]  TYPE_ACK      = 8'd2;
  localparam logic [7:0]  PAT_STEP      = 8'd31;
  localparam logic [7:0]  PAT_START     = 8'(HDR_LEN * {8'b0, PAT_STEP});
  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [7:0]  MAGIC [4]     = '{8'h4e, 8'h53, 8'h50, 8'h4c};

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 168;

  typedef struct packed {
    logic               frame_ok;
    logic               is_ack;
    logic [31:0]        seq_number;
    logic signed [63:0] sent_time;
    logic signed [63:0] recv_time;
  } pfc_result_t;

endpackage

// ===== rtl/pfc_byte_check.sv =====
// Per-byte frame checks, field capture and frame state for the probe frame checker.
module pfc_byte_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [7:0]          frame_version,
  output pfc_pkg::pfc_result_t result
);
  import pfc_pkg::*;

  localparam logic [15:0] POS_VERSION = 16'd4;
  localparam logic [15:0] POS_TYPE    = 16'd5;
  localparam logic [15:0] POS_LEN_HI  = 16'd6;
  localparam logic [15:0] POS_LEN_LO  = 16'd7;
  localparam logic [15:0] POS_SENT    = 16'd12;
  localparam logic [15:0] POS_RECV    = 16'd20;
  localparam logic [15:0] POS_SIZE    = 16'd28;
  localparam logic [15:0] POS_MAX     = 16'hffff;

  logic [15:0] pos_r,   pos_nxt;
  logic        bad_r,   bad_nxt;
  logic [7:0]  type_r,  type_nxt;
  logic [31:0] seq_r,   seq_nxt;
  logic [63:0] sent_r,  sent_nxt;
  logic [63:0] recv_r,  recv_nxt;
  logic [31:0] size_r,  size_nxt;
  logic [7:0]  pat_r,   pat_nxt;
  logic        ok;

  always_comb begin
    bad_nxt  = bad_r;
    type_nxt = type_r;
    seq_nxt  = seq_r;
    sent_nxt = sent_r;
    recv_nxt = recv_r;
    size_nxt = size_r;
    pat_nxt  = pat_r;
    if (pos_r >= FRAME_BYTES) begin
      bad_nxt = 1'b1;
    end else if (pos_r < POS_VERSION) begin
      if (data_byte != MAGIC[pos_r[1:0]]) bad_nxt = 1'b1;
    end else if (pos_r == POS_VERSION) begin
      if (data_byte != frame_version) bad_nxt = 1'b1;
    end else if (pos_r == POS_TYPE) begin
      type_nxt = data_byte;
      if (!(data_byte inside {TYPE_PROBE, TYPE_ACK})) bad_nxt = 1'b1;
    end else if (pos_r == POS_LEN_HI) begin
      if (data_byte != HDR_LEN[15:8]) bad_nxt = 1'b1;
    end else if (pos_r == POS_LEN_LO) begin
      if (data_byte != HDR_LEN[7:0]) bad_nxt = 1'b1;
    end else if (pos_r < POS_SENT) begin
      seq_nxt = {seq_r[23:0], data_byte};
    end else if (pos_r < POS_RECV) begin
      sent_nxt = {sent_r[55:0], data_byte};
    end else if (pos_r < POS_SIZE) begin
      recv_nxt = {recv_r[55:0], data_byte};
    end else if (pos_r < HDR_LEN) begin
      size_nxt = {size_r[23:0], data_byte};
      if (pos_r == HDR_LEN - 16'd1) begin
        if (size_nxt != {16'b0, FRAME_BYTES}) bad_nxt = 1'b1;
        pat_nxt = seq_r[7:0] + PAT_START;
      end
    end else begin
      if (data_byte != pat_r) bad_nxt = 1'b1;
      pat_nxt = pat_r + PAT_STEP;
    end
    pos_nxt = (pos_r != POS_MAX) ? pos_r + 16'd1 : pos_r;
  end

  always_comb begin
    ok                = !bad_nxt && (pos_r == FRAME_BYTES - 16'd1);
    result.frame_ok   = ok;
    result.is_ack     = ok && (type_nxt == TYPE_ACK);
    result.seq_number = ok ? seq_nxt : 32'd0;
    result.sent_time  = ok ? sent_nxt : 64'd0;
    result.recv_time  = ok ? recv_nxt : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r  <= '0;
      bad_r  <= 1'b0;
      type_r <= '0;
      seq_r  <= '0;
      sent_r <= '0;
      recv_r <= '0;
      size_r <= '0;
      pat_r  <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      type_r <= type_nxt;
      seq_r  <= seq_nxt;
      sent_r <= sent_nxt;
      recv_r <= recv_nxt;
      size_r <= size_nxt;
      pat_r  <= pat_nxt;
    end
  end

endmodule

// ===== rtl/probe_frame_checker_core.sv =====
// Probe frame checker top level: input register, byte checker and output register.
// A result word is captured in the output register when its last byte leaves the input register.
// Throughput: one byte word per cycle, set by the single-pass byte checker between
// the input register and the output register; a closing byte holds the input
// only while the result register is full and not taken in that cycle.
// Reset: rst_n low at a clock edge clears all frame state, both valid flags and
// sets frame_version back to 1.
module probe_frame_checker_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pfc_pkg::IN_TDATA_W-1:0]        in_tdata,  // [7:0] data_byte
  input  logic                                  in_tlast,  // last_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] frame_ok, [1] is_ack, [33:2] seq_number, [97:34] sent_time,
  // [161:98] recv_time, [167:162] zero
  output logic [pfc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [7:0]                            cfg_wr_data
);
  import pfc_pkg::*;

  logic [7:0]             frame_version_r;
  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_free;
  logic                   s1_adv;
  logic                   in_acc;
  pfc_result_t            res;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  pfc_byte_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .data_byte    (s1_byte_r),
    .last_byte    (s1_last_r),
    .frame_version(frame_version_r),
    .result       (res)
  );

  // hold the configured version
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_version_r <= VERSION_RESET;
    end else if (cfg_wr_en) begin
      frame_version_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= {6'b0, res.recv_time, res.sent_time, res.seq_number,
                     res.is_ack, res.frame_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
